@@ rtl/kt2d_pkg.sv @@
// Package for the two-dimensional constant-velocity tracker.
// Holds the sequencer state codes, the micro-operation set and the micro-program ROM.
// Depends on nothing; used by kalman_tracker_2d_const_velocity.
`timescale 1ns / 1ps
`default_nettype none

package kt2d_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_EX    = 8'b0000_0100,
    S_MR    = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_OUT0  = 8'b0010_0000,
    S_OUT1  = 8'b0100_0000,
    S_OUT2  = 8'b1000_0000
  } state_e;

  // Micro-operations. MADD: d = c + a*b, MSUB: d = c - a*b.
  typedef enum logic [3:0] {
    OP_END,
    OP_LDR,
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MADD,
    OP_MSUB,
    OP_DIV
  } op_e;

  // Sources for a register load.
  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_DT,
    SRC_QPOS,
    SRC_QVEL,
    SRC_R,
    SRC_PINIT,
    SRC_PINIT_RST,
    SRC_ZX,
    SRC_ZY
  } src_e;

  // Actions of an input beat.
  localparam logic [1:0] ACT_INIT    = 2'd0;
  localparam logic [1:0] ACT_PREDICT = 2'd1;
  localparam logic [1:0] ACT_UPDATE  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_STEP_TIME = 3'd0;
  localparam logic [2:0] REG_QPOS      = 3'd1;
  localparam logic [2:0] REG_QVEL      = 3'd2;
  localparam logic [2:0] REG_MEAS      = 3'd3;
  localparam logic [2:0] REG_PINIT     = 3'd4;

  // Configuration reset values.
  localparam logic [30:0] RST_STEP_TIME = 31'd2185;
  localparam logic [30:0] RST_QPOS      = 31'd65536;
  localparam logic [30:0] RST_QVEL      = 31'd32768;
  localparam logic [30:0] RST_MEAS      = 31'd1638400;
  localparam logic [30:0] RST_PINIT     = 31'd65536000;

  // Scratch memory map. Covariance is row-major at 0..15.
  localparam int A_EST = 16;
  localparam int A_DT  = 20;
  localparam int A_QP  = 21;
  localparam int A_QV  = 22;
  localparam int A_R   = 23;
  localparam int A_Z   = 24;
  localparam int A_S00 = 25;
  localparam int A_S11 = 26;
  localparam int A_R10 = 27;
  localparam int A_R01 = 28;
  localparam int A_D0  = 29;
  localparam int A_D1  = 30;
  localparam int A_T   = 31;
  localparam int A_E0  = 32;
  localparam int A_E1  = 33;
  localparam int A_K0  = 34;
  localparam int A_K1  = 38;
  localparam int A_NP  = 48;

  localparam int MEM_DEPTH = 64;
  localparam int AW        = 6;

  // Program entry points.
  localparam logic [7:0] PC_INIT    = 8'd0;
  localparam logic [7:0] PC_RESET   = 8'd21;
  localparam logic [7:0] PC_PREDICT = 8'd42;
  localparam logic [7:0] PC_UPDATE  = 8'd68;

  typedef struct packed {
    op_e           op;
    src_e          src;
    logic [AW-1:0] d;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [AW-1:0] c;
  } instr_t;

  function automatic instr_t mk(op_e op, src_e src, int d, int a, int b, int c);
    instr_t r;
    r.op  = op;
    r.src = src;
    r.d   = AW'(d);
    r.a   = AW'(a);
    r.b   = AW'(b);
    r.c   = AW'(c);
    return r;
  endfunction

  // Micro-program ROM: init, reset pass, predict and update, each closed by OP_END.
  function automatic instr_t micro(logic [7:0] pc);
    instr_t r;
    int     k;
    int     kk;
    int     n;
    bit     rst;
    src_e   s;
    r  = mk(OP_END, SRC_ZERO, 0, 0, 0, 0);
    k  = int'(pc);
    if (k < int'(PC_PREDICT)) begin
      // Init and reset pass share one shape.
      rst = (k >= int'(PC_RESET));
      kk  = rst ? k - int'(PC_RESET) : k;
      if (kk < 4) begin
        if (rst || kk >= 2) s = SRC_ZERO;
        else if (kk == 0)   s = SRC_ZX;
        else                s = SRC_ZY;
        r = mk(OP_LDR, s, A_EST + kk, 0, 0, 0);
      end else if (kk < 20) begin
        n = kk - 4;
        if (n == 0 || n == 5 || n == 10 || n == 15) s = rst ? SRC_PINIT_RST : SRC_PINIT;
        else s = SRC_ZERO;
        r = mk(OP_LDR, s, n, 0, 0, 0);
      end
    end else if (k < int'(PC_UPDATE)) begin
      kk = k - int'(PC_PREDICT);
      if (kk == 0) r = mk(OP_LDR, SRC_DT, A_DT, 0, 0, 0);
      if (kk == 1) r = mk(OP_LDR, SRC_QPOS, A_QP, 0, 0, 0);
      if (kk == 2) r = mk(OP_LDR, SRC_QVEL, A_QV, 0, 0, 0);
      if (kk == 3) r = mk(OP_MADD, SRC_ZERO, A_EST, A_DT, A_EST + 2, A_EST);
      if (kk == 4) r = mk(OP_MADD, SRC_ZERO, A_EST + 1, A_DT, A_EST + 3, A_EST + 1);
      // Rows 0 and 1 of A*P.
      for (int i = 0; i < 8; i++) begin
        if (kk == 5 + i) r = mk(OP_MADD, SRC_ZERO, i, A_DT, 8 + i, i);
      end
      // Columns 0 and 1 of (A*P)*A^T.
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 2; c++) begin
          if (kk == 13 + i * 2 + c)
            r = mk(OP_MADD, SRC_ZERO, i * 4 + c, A_DT, i * 4 + c + 2, i * 4 + c);
        end
      end
      if (kk == 21) r = mk(OP_ADD, SRC_ZERO, 0, 0, A_QP, 0);
      if (kk == 22) r = mk(OP_ADD, SRC_ZERO, 5, 5, A_QP, 0);
      if (kk == 23) r = mk(OP_ADD, SRC_ZERO, 10, 10, A_QV, 0);
      if (kk == 24) r = mk(OP_ADD, SRC_ZERO, 15, 15, A_QV, 0);
    end else begin
      kk = k - int'(PC_UPDATE);
      if (kk == 0) r = mk(OP_LDR, SRC_R, A_R, 0, 0, 0);
      if (kk == 1) r = mk(OP_ADD, SRC_ZERO, A_S00, 0, A_R, 0);
      if (kk == 2) r = mk(OP_ADD, SRC_ZERO, A_S11, 5, A_R, 0);
      if (kk == 3) r = mk(OP_DIV, SRC_ZERO, A_R10, 4, A_S11, 0);
      if (kk == 4) r = mk(OP_DIV, SRC_ZERO, A_R01, 1, A_S00, 0);
      if (kk == 5) r = mk(OP_MSUB, SRC_ZERO, A_D0, 1, A_R10, A_S00);
      if (kk == 6) r = mk(OP_MSUB, SRC_ZERO, A_D1, 4, A_R01, A_S11);
      // Gain rows.
      for (int i = 0; i < 4; i++) begin
        if (kk == 7 + i * 4) r = mk(OP_MSUB, SRC_ZERO, A_T, i * 4 + 1, A_R10, i * 4);
        if (kk == 8 + i * 4) r = mk(OP_DIV, SRC_ZERO, A_K0 + i, A_T, A_D0, 0);
        if (kk == 9 + i * 4) r = mk(OP_MSUB, SRC_ZERO, A_T, i * 4, A_R01, i * 4 + 1);
        if (kk == 10 + i * 4) r = mk(OP_DIV, SRC_ZERO, A_K1 + i, A_T, A_D1, 0);
      end
      // Innovation.
      if (kk == 23) r = mk(OP_LDR, SRC_ZX, A_Z, 0, 0, 0);
      if (kk == 24) r = mk(OP_SUB, SRC_ZERO, A_E0, A_Z, A_EST, 0);
      if (kk == 25) r = mk(OP_LDR, SRC_ZY, A_Z, 0, 0, 0);
      if (kk == 26) r = mk(OP_SUB, SRC_ZERO, A_E1, A_Z, A_EST + 1, 0);
      // State correction.
      for (int i = 0; i < 4; i++) begin
        if (kk == 27 + i * 3) r = mk(OP_MUL, SRC_ZERO, A_T, A_K0 + i, A_E0, 0);
        if (kk == 28 + i * 3) r = mk(OP_MADD, SRC_ZERO, A_T, A_K1 + i, A_E1, A_T);
        if (kk == 29 + i * 3) r = mk(OP_ADD, SRC_ZERO, A_EST + i, A_EST + i, A_T, 0);
      end
      // New covariance into the shadow area, then copy back.
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (kk == 39 + (i * 4 + j) * 2)
            r = mk(OP_MSUB, SRC_ZERO, A_T, A_K0 + i, j, i * 4 + j);
          if (kk == 40 + (i * 4 + j) * 2)
            r = mk(OP_MSUB, SRC_ZERO, A_NP + i * 4 + j, A_K1 + i, 4 + j, A_T);
        end
      end
      for (int i = 0; i < 16; i++) begin
        if (kk == 71 + i) r = mk(OP_MOV, SRC_ZERO, i, A_NP + i, 0, 0);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/kalman_tracker_2d_const_velocity.sv @@
// Top level of the two-dimensional constant-velocity tracker.
// A micro-programmed sequencer runs over a scratch memory holding state and covariance.
// Depends on kt2d_pkg.
//
//   Port group    Direction  Contents
//   in_*          in         action, meas_x, meas_y
//   out_*         out        est_x, est_y, est_vx, est_vy, saturated
//   cfg_*         in         register index, write data
//
// Each accepted beat of a known action runs its micro-program, then the estimate is read out.
// Divides use a bit-serial divider, and a zero divisor skips the divide. Every micro-operation
// reads the scratch memory, computes and writes back before the next one is fetched, so no
// forwarding is needed. After reset a pass clears the state estimate and loads the covariance;
// no beat is taken meanwhile. A new beat is taken only with the sequencer idle; a stalled
// result holds the last step.
`timescale 1ns / 1ps
`default_nettype none

module kalman_tracker_2d_const_velocity
  import kt2d_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] meas_x_i,
  input  wire logic signed [31:0] meas_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      est_x_o,
  output logic signed [31:0]      est_y_o,
  output logic signed [31:0]      est_vx_o,
  output logic signed [31:0]      est_vy_o,
  output logic                    saturated_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [30:0]        cfg_data_i
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int QW = W + F;
  localparam int EW = (2 * W + 1 > QW + 1) ? 2 * W + 1 : QW + 1;
  localparam int CW = $clog2(QW + 1);
  localparam logic [63:0] VMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};

  typedef struct packed {
    logic         sat;
    logic [W-1:0] v;
  } res_t;

  // Arithmetic helpers.
  function automatic logic [W-1:0] mag(logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic res_t from_mag(logic neg, logic [EW-1:0] m);
    res_t          r;
    logic [EW-1:0] lim;
    lim = EW'(VMAX) + EW'(neg);
    r.sat = (m > lim);
    if (r.sat) r.v = neg ? VMIN : VMAX;
    else       r.v = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    return r;
  endfunction

  function automatic res_t qadd(logic [W-1:0] a, logic [W-1:0] b);
    res_t     r;
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    r.sat = (s[W] != s[W-1]);
    r.v   = r.sat ? (s[W] ? VMIN : VMAX) : s[W-1:0];
    return r;
  endfunction

  function automatic res_t qsub(logic [W-1:0] a, logic [W-1:0] b);
    res_t     r;
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    r.sat = (s[W] != s[W-1]);
    r.v   = r.sat ? (s[W] ? VMIN : VMAX) : s[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] regval(logic [30:0] r);
    logic [63:0] r64;
    r64 = {33'd0, r};
    return (r64 > VMAX64) ? VMAX : W'(r64);
  endfunction

  function automatic res_t in_clamp(logic signed [31:0] m);
    res_t               r;
    logic signed [63:0] m64;
    m64 = 64'(m);
    r.sat = 1'b0;
    r.v   = W'(m64);
    if (m64 > $signed(VMAX64)) begin
      r.sat = 1'b1;
      r.v   = VMAX;
    end else if (m64 < -$signed(VMAX64) - 64'sd1) begin
      r.sat = 1'b1;
      r.v   = VMIN;
    end
    return r;
  endfunction

  function automatic logic [32:0] out_clamp(logic [W-1:0] v);
    logic signed [63:0] v64;
    v64 = 64'($signed(v));
    if (v64 > 64'sd2147483647)       return {1'b1, 32'h7FFF_FFFF};
    else if (v64 < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    else                              return {1'b0, v64[31:0]};
  endfunction

  // Configuration registers.
  logic [30:0] step_q, qpos_q, qvel_q, meas_q, pinit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= RST_STEP_TIME;
      qpos_q  <= RST_QPOS;
      qvel_q  <= RST_QVEL;
      meas_q  <= RST_MEAS;
      pinit_q <= RST_PINIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEP_TIME: step_q  <= cfg_data_i;
        REG_QPOS:      qpos_q  <= cfg_data_i;
        REG_QVEL:      qvel_q  <= cfg_data_i;
        REG_MEAS:      meas_q  <= cfg_data_i;
        REG_PINIT:     pinit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_e              state_q, state_d;
  logic [7:0]          pc_q, pc_d;
  logic                rstpass_q, rstpass_d;
  logic                flag_q, flag_d;
  logic [W-1:0]        zx_q, zx_d, zy_q, zy_d;
  logic [2*W-1:0]      prod_q, prod_d;
  logic                neg_q, neg_d;
  logic [W-1:0]        ub_q, ub_d;
  logic [W:0]          rem_q, rem_d;
  logic [QW-1:0]       num_q, num_d, quo_q, quo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [W-1:0]        xo_q, xo_d, yo_q, yo_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         ox_q, ox_d, oy_q, oy_d, ovx_q, ovx_d, ovy_q, ovy_d;
  logic                osat_q, osat_d;

  // Scratch memory.
  logic [W-1:0]        mem [MEM_DEPTH];
  logic [W-1:0]        rd0_q, rd1_q;
  logic [AW-1:0]       ra0, ra1, wa;
  logic [W-1:0]        wd;
  logic                we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  instr_t ins;
  assign ins = micro(pc_q);

  // Combined values for the execute, multiply-round and divide steps.
  res_t           r_add, r_sub, r_m, r_mc, r_div, cx, cy;
  logic [W-1:0]   src_val;
  logic [2*W:0]   rnd;
  logic [W:0]     trial;
  logic [QW:0]    q_rnd;
  logic           up;
  logic [32:0]    c0, c1, c2, c3;

  always_comb begin
    r_add = qadd(rd0_q, rd1_q);
    r_sub = qsub(rd0_q, rd1_q);
    rnd   = {1'b0, prod_q} + ((2*W+1)'(1) << (F - 1));
    r_m   = from_mag(neg_q, EW'(rnd >> F));
    r_mc  = (ins.op == OP_MADD) ? qadd(rd0_q, r_m.v) : qsub(rd0_q, r_m.v);
    trial = {rem_q[W-1:0], num_q[QW-1]};
    up    = ({rem_q, 1'b0} >= {2'b00, ub_q});
    q_rnd = {1'b0, quo_q} + (QW+1)'(up);
    r_div = from_mag(neg_q, EW'(q_rnd));
    cx    = in_clamp(meas_x_i);
    cy    = in_clamp(meas_y_i);
    c0    = out_clamp(xo_q);
    c1    = out_clamp(yo_q);
    c2    = out_clamp(rd0_q);
    c3    = out_clamp(rd1_q);
    case (ins.src)
      SRC_DT:        src_val = regval(step_q);
      SRC_QPOS:      src_val = regval(qpos_q);
      SRC_QVEL:      src_val = regval(qvel_q);
      SRC_R:         src_val = regval(meas_q);
      SRC_PINIT:     src_val = regval(pinit_q);
      SRC_PINIT_RST: src_val = regval(RST_PINIT);
      SRC_ZX:        src_val = zx_q;
      SRC_ZY:        src_val = zy_q;
      default:       src_val = '0;
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    rstpass_d   = rstpass_q;
    flag_d      = flag_q;
    zx_d        = zx_q;
    zy_d        = zy_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    ub_d        = ub_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    xo_d        = xo_q;
    yo_d        = yo_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ox_d        = ox_q;
    oy_d        = oy_q;
    ovx_d       = ovx_q;
    ovy_d       = ovy_q;
    osat_d      = osat_q;
    ra0         = ins.a;
    ra1         = ins.b;
    wa          = ins.d;
    wd          = '0;
    we          = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          zx_d   = cx.v;
          zy_d   = cy.v;
          flag_d = cx.sat | cy.sat;
          case (action_i)
            ACT_INIT:    pc_d = PC_INIT;
            ACT_PREDICT: pc_d = PC_PREDICT;
            ACT_UPDATE:  pc_d = PC_UPDATE;
            default:     pc_d = pc_q;
          endcase
          state_d = (action_i inside {ACT_INIT, ACT_PREDICT, ACT_UPDATE}) ? S_FETCH : S_OUT0;
        end
      end
      S_FETCH: begin
        if (ins.op == OP_END) begin
          rstpass_d = 1'b0;
          state_d   = rstpass_q ? S_IDLE : S_OUT0;
        end else begin
          state_d = S_EX;
        end
      end
      S_EX: begin
        case (ins.op)
          OP_LDR: begin
            we = 1'b1;
            wd = src_val;
          end
          OP_MOV: begin
            we = 1'b1;
            wd = rd0_q;
          end
          OP_ADD: begin
            we     = 1'b1;
            wd     = r_add.v;
            flag_d = flag_q | r_add.sat;
          end
          OP_SUB: begin
            we     = 1'b1;
            wd     = r_sub.v;
            flag_d = flag_q | r_sub.sat;
          end
          OP_DIV: begin
            if (rd1_q == '0) begin
              we     = 1'b1;
              flag_d = 1'b1;
              if (rd0_q == '0)   wd = '0;
              else if (rd0_q[W-1]) wd = VMIN;
              else               wd = VMAX;
            end
          end
          default: begin
            // Multiply family: fetch the addend while the product settles.
            ra0 = ins.c;
          end
        endcase
        neg_d  = rd0_q[W-1] ^ rd1_q[W-1];
        prod_d = mag(rd0_q) * mag(rd1_q);
        ub_d   = mag(rd1_q);
        num_d  = {mag(rd0_q), {F{1'b0}}};
        rem_d  = '0;
        quo_d  = '0;
        cnt_d  = CW'(QW);
        if (ins.op inside {OP_MUL, OP_MADD, OP_MSUB}) begin
          state_d = S_MR;
        end else if (ins.op == OP_DIV && rd1_q != '0) begin
          state_d = S_DIV;
        end else begin
          pc_d    = pc_q + 8'd1;
          state_d = S_FETCH;
        end
      end
      S_MR: begin
        we = 1'b1;
        if (ins.op == OP_MUL) begin
          wd     = r_m.v;
          flag_d = flag_q | r_m.sat;
        end else begin
          wd     = r_mc.v;
          flag_d = flag_q | r_m.sat | r_mc.sat;
        end
        pc_d    = pc_q + 8'd1;
        state_d = S_FETCH;
      end
      S_DIV: begin
        // One quotient bit per cycle, then round half away from zero.
        if (cnt_q != '0) begin
          if (trial >= {1'b0, ub_q}) begin
            rem_d = trial - {1'b0, ub_q};
            quo_d = {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_d = trial;
            quo_d = {quo_q[QW-2:0], 1'b0};
          end
          num_d = {num_q[QW-2:0], 1'b0};
          cnt_d = cnt_q - 1'b1;
        end else begin
          we      = 1'b1;
          wd      = r_div.v;
          flag_d  = flag_q | r_div.sat;
          pc_d    = pc_q + 8'd1;
          state_d = S_FETCH;
        end
      end
      S_OUT0: begin
        ra0     = AW'(A_EST);
        ra1     = AW'(A_EST + 1);
        state_d = S_OUT1;
      end
      S_OUT1: begin
        xo_d    = rd0_q;
        yo_d    = rd1_q;
        ra0     = AW'(A_EST + 2);
        ra1     = AW'(A_EST + 3);
        state_d = S_OUT2;
      end
      S_OUT2: begin
        ra0 = AW'(A_EST + 2);
        ra1 = AW'(A_EST + 3);
        if (!out_valid_q || out_ready_i) begin
          ox_d        = c0[31:0];
          oy_d        = c1[31:0];
          ovx_d       = c2[31:0];
          ovy_d       = c3[31:0];
          osat_d      = flag_q | c0[32] | c1[32] | c2[32] | c3[32];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      pc_q        <= PC_RESET;
      rstpass_q   <= 1'b1;
      flag_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      rstpass_q   <= rstpass_d;
      flag_q      <= flag_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    zx_q   <= zx_d;
    zy_q   <= zy_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    ub_q   <= ub_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    xo_q   <= xo_d;
    yo_q   <= yo_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    ovx_q  <= ovx_d;
    ovy_q  <= ovy_d;
    osat_q <= osat_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign est_x_o     = ox_q;
  assign est_y_o     = oy_q;
  assign est_vx_o    = ovx_q;
  assign est_vy_o    = ovy_q;
  assign saturated_o = osat_q;

`ifndef SYNTHESIS
  // An accepted beat always starts work.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted beat left the sequencer idle");

  // The scratch memory is never written while idle.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we)
    else $error("memory write while idle");

  // A new result is only raised from the final readout step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT2))
    else $error("result raised outside readout");

  // The divider count never exceeds the quotient width.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= CW'(QW)))
    else $error("divider count out of range");
`endif

endmodule

`default_nettype wire
